FILE: src/rldac_pkg.sv
`timescale 1ns / 1ps
package rldac_pkg;

	localparam int DEFAULT_LADDER_BITS = 8;
	localparam int NUM_WEIGHTS = 8;
	localparam int WIDX_W = 3;
	localparam int VOLT_W = 24;
	localparam int CODE_W = 8;
	localparam int FRAC_W = 16;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 48;

	typedef logic signed [VOLT_W-1:0] volt_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BIAS      = 4'd0,
		REG_W01       = 4'd1,
		REG_W23       = 4'd2,
		REG_W45       = 4'd3,
		REG_W67       = 4'd4,
		REG_FILT_EN   = 4'd5,
		REG_FILT_COEF = 4'd6,
		REG_SNAP_THR  = 4'd7
	} reg_idx_t;

	typedef struct packed {
		volt_t                          bias;
		logic [NUM_WEIGHTS-1:0][VOLT_W-1:0] weight;
		logic                           filt_en;
		logic [15:0]                    filt_coef;
		logic [15:0]                    snap_thr;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_LEVEL,
		ST_MUL1,
		ST_INTERP,
		ST_DIFF,
		ST_MUL2,
		ST_FINAL
	} state_t;

	typedef struct packed {
		logic load;
		logic acc_en;
		logic level_en;
		logic mul1_en;
		logic interp_en;
		logic diff_en;
		logic mul2_en;
		logic final_en;
	} cmd_t;

	typedef struct packed {
		logic acc_last;
	} stat_t;

endpackage

FILE: src/rldac_cfg.sv
`timescale 1ns / 1ps
module rldac_cfg
	import rldac_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bias      <= '0;
			cfg_q.weight    <= '0;
			cfg_q.filt_en   <= 1'b0;
			cfg_q.filt_coef <= '0;
			cfg_q.snap_thr  <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BIAS:      cfg_q.bias <= cfg_wdata[VOLT_W-1:0];
				REG_W01: begin
					cfg_q.weight[0] <= cfg_wdata[VOLT_W-1:0];
					cfg_q.weight[1] <= cfg_wdata[2*VOLT_W-1:VOLT_W];
				end
				REG_W23: begin
					cfg_q.weight[2] <= cfg_wdata[VOLT_W-1:0];
					cfg_q.weight[3] <= cfg_wdata[2*VOLT_W-1:VOLT_W];
				end
				REG_W45: begin
					cfg_q.weight[4] <= cfg_wdata[VOLT_W-1:0];
					cfg_q.weight[5] <= cfg_wdata[2*VOLT_W-1:VOLT_W];
				end
				REG_W67: begin
					cfg_q.weight[6] <= cfg_wdata[VOLT_W-1:0];
					cfg_q.weight[7] <= cfg_wdata[2*VOLT_W-1:VOLT_W];
				end
				REG_FILT_EN:   cfg_q.filt_en <= cfg_wdata[0];
				REG_FILT_COEF: cfg_q.filt_coef <= cfg_wdata[15:0];
				REG_SNAP_THR:  cfg_q.snap_thr <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/rldac_ctrl.sv
`timescale 1ns / 1ps
module rldac_ctrl
	import rldac_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	// The result register may be refilled once its beat is gone or leaves now.
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_ACC;
			ST_ACC:    if (stat.acc_last) state_d = ST_LEVEL;
			ST_LEVEL:  state_d = ST_MUL1;
			ST_MUL1:   state_d = ST_INTERP;
			ST_INTERP: state_d = ST_DIFF;
			ST_DIFF:   state_d = ST_MUL2;
			ST_MUL2:   state_d = ST_FINAL;
			ST_FINAL:  if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_ACC:    cmd.acc_en = 1'b1;
			ST_LEVEL:  cmd.level_en = 1'b1;
			ST_MUL1:   cmd.mul1_en = 1'b1;
			ST_INTERP: cmd.interp_en = 1'b1;
			ST_DIFF:   cmd.diff_en = 1'b1;
			ST_MUL2:   cmd.mul2_en = 1'b1;
			ST_FINAL:  cmd.final_en = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.final_en)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: src/rldac_dp.sv
`timescale 1ns / 1ps
module rldac_dp
	import rldac_pkg::*;
#(
	parameter int LADDER_BITS = DEFAULT_LADDER_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  cmd_t              cmd,
	output stat_t             stat,
	input  logic [CODE_W-1:0] code,
	input  logic [FRAC_W-1:0] fraction,
	output volt_t             voltage
);

	localparam int ACC_W = VOLT_W + 4;
	localparam logic [WIDX_W-1:0] LAST_IDX = WIDX_W'(LADDER_BITS - 1);

	function automatic volt_t sat_volt(input logic signed [ACC_W-1:0] v);
		volt_t r;
		if (v > ACC_W'(signed'(24'sh7FFFFF)))
			r = 24'sh7FFFFF;
		else if (v < ACC_W'(signed'(24'sh800000)))
			r = 24'sh800000;
		else
			r = v[VOLT_W-1:0];
		return r;
	endfunction

	logic [CODE_W-1:0]         code_q;
	logic [FRAC_W-1:0]         frac_q;
	logic [WIDX_W-1:0]         idx_q;
	logic signed [ACC_W-1:0]   acc_q;
	volt_t                     prev_level_q;
	volt_t                     last_q;
	logic signed [VOLT_W:0]    diff1_q;
	logic signed [41:0]        p1_q;
	volt_t                     v_q;
	logic signed [VOLT_W:0]    diff2_q;
	logic                      snap_q;
	logic signed [41:0]        p2_q;
	volt_t                     out_level_q;
	volt_t                     voltage_q;

	volt_t                     weight_sel;
	volt_t                     level;
	logic signed [VOLT_W:0]    diff2;
	logic [VOLT_W:0]           mag;
	logic signed [ACC_W-1:0]   filt_sum;
	volt_t                     next_out;

	assign weight_sel = cfg.weight[idx_q];
	assign level      = sat_volt(acc_q);
	assign diff2      = {v_q[VOLT_W-1], v_q} - {out_level_q[VOLT_W-1], out_level_q};
	assign mag        = diff2[VOLT_W] ? (VOLT_W+1)'(-diff2) : diff2;
	// The filter step is floor(diff * coef / 2^16), i.e. an arithmetic shift.
	assign filt_sum   = {{4{out_level_q[VOLT_W-1]}}, out_level_q}
	                  + {{2{p2_q[41]}}, p2_q[41:16]};

	always_comb begin
		if (!cfg.filt_en || snap_q)
			next_out = v_q;
		else
			next_out = sat_volt(filt_sum);
	end

	assign stat.acc_last = (idx_q == LAST_IDX);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			code_q <= code;
			frac_q <= fraction;
			idx_q  <= '0;
			acc_q  <= {{4{cfg.bias[VOLT_W-1]}}, cfg.bias};
		end
		if (cmd.acc_en) begin
			if (code_q[0])
				acc_q <= acc_q + {{4{weight_sel[VOLT_W-1]}}, weight_sel};
			code_q <= code_q >> 1;
			idx_q  <= idx_q + 1'b1;
		end
		if (cmd.level_en) begin
			last_q  <= prev_level_q;
			diff1_q <= {level[VOLT_W-1], level} - {prev_level_q[VOLT_W-1], prev_level_q};
			v_q     <= level;
		end
		if (cmd.mul1_en)
			p1_q <= diff1_q * $signed({1'b0, frac_q});
		// The interpolated value lies between the two levels, so the low bits suffice.
		if (cmd.interp_en && frac_q != '0)
			v_q <= last_q + p1_q[39:16];
		if (cmd.diff_en) begin
			diff2_q <= diff2;
			snap_q  <= mag < {9'd0, cfg.snap_thr};
		end
		if (cmd.mul2_en)
			p2_q <= diff2_q * $signed({1'b0, cfg.filt_coef});
		if (cmd.final_en)
			voltage_q <= next_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= '0;
			out_level_q  <= '0;
		end else begin
			if (cmd.level_en)
				prev_level_q <= level;
			if (cmd.final_en)
				out_level_q <= next_out;
		end
	end

	assign voltage = voltage_q;

endmodule

FILE: src/resistor_ladder_dac_with_rc_filter_unit.sv
`timescale 1ns / 1ps
// Resistor ladder DAC level generator with interpolation and a one-pole RC filter.
// Input channel (in_valid/in_ready) carries a ladder code and a timing fraction;
// output channel (out_valid/out_ready) carries one Q8.16 voltage per input beat.
// Configuration is a write-only port (cfg_we, cfg_index, cfg_wdata); the user
// must see that it is used only while no sample is in flight; the block does
// not enforce this. A write is seen by the next sample. The ladder sum adds one
// bit weight per cycle; the two dependent multiplies (interpolation, filter)
// get states of their own. One sample is worked on at a time; in_ready is high
// only between samples, so a new sample is not accepted until the previous one
// has left the last step. The result sits in an output register, so the next
// sample is accepted while the previous beat still waits. If the receiver
// stalls, the block finishes the next sample and then holds in its last step
// until the register is free. Reset clears the previous ladder level, the filter
// state, the controller and the configuration (snap threshold resets to one
// LSB), not the other datapath registers; no output beat is pending after reset.
module resistor_ladder_dac_with_rc_filter_unit
	import rldac_pkg::*;
#(
	parameter int LADDER_BITS = DEFAULT_LADDER_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CODE_W-1:0]     code,
	input  logic [FRAC_W-1:0]     fraction,
	output logic                  out_valid,
	input  logic                  out_ready,
	output volt_t                 voltage
);

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	rldac_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	rldac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rldac_dp #(
		.LADDER_BITS (LADDER_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.stat     (stat),
		.code     (code),
		.fraction (fraction),
		.voltage  (voltage)
	);

`ifndef SYNTHESIS
	// Only one sample is in flight.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a sample was in flight");

	// A waiting result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.final_en |-> (!out_valid || out_ready))
		else $error("result register written while its beat was pending");

	// A new output beat comes only from the final step.
	a_beat_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.final_en))
		else $error("output beat appeared without a final step");
`endif

endmodule

FILE: test/rldac_checker.sv
`timescale 1ns / 1ps
module rldac_checker
	import rldac_pkg::*;
#(
	parameter int LADDER_BITS = DEFAULT_LADDER_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [CODE_W-1:0]     code,
	input  logic [FRAC_W-1:0]     fraction,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  volt_t                 voltage,
	output int                    fail_count,
	output int                    pending
);

	localparam longint VOLT_MAX = 64'sd8388607;
	localparam longint VOLT_MIN = -64'sd8388608;

	// Shadow copy of the register file.
	volt_t       bias_q;
	volt_t       weight_q [NUM_WEIGHTS];
	logic        filt_on_q;
	logic [15:0] coef_q;
	logic [15:0] snap_q;

	longint last_level;
	longint filt_level;
	volt_t  voltage_due [$];

	function automatic longint clamp_volt(input longint v);
		if (v > VOLT_MAX) begin
			return VOLT_MAX;
		end
		if (v < VOLT_MIN) begin
			return VOLT_MIN;
		end
		return v;
	endfunction

	task automatic predict_voltage(input logic [CODE_W-1:0] c, input logic [FRAC_W-1:0] f);
		longint level;
		longint start;
		longint target;
		longint diff;
		longint mag;
		level = longint'(bias_q);
		for (int b = 0; b < LADDER_BITS && b < NUM_WEIGHTS; b++) begin
			if (c[b]) begin
				level += longint'(weight_q[b]);
			end
		end
		level = clamp_volt(level);
		start = last_level;
		last_level = level;
		target = level;
		// Arithmetic shift of a signed product floors, as the truncation requires.
		if (f != '0) begin
			target = start + (((level - start) * longint'(f)) >>> 16);
		end
		if (filt_on_q) begin
			diff = target - filt_level;
			mag = (diff < 0) ? -diff : diff;
			if (mag < longint'(snap_q)) begin
				filt_level = target;
			end else begin
				filt_level = clamp_volt(filt_level + ((diff * longint'(coef_q)) >>> 16));
			end
		end else begin
			filt_level = target;
		end
		voltage_due.push_back(volt_t'(filt_level));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q = '0;
			for (int k = 0; k < NUM_WEIGHTS; k++) begin
				weight_q[k] = '0;
			end
			filt_on_q = 1'b0;
			coef_q = '0;
			snap_q = 16'd1;
			last_level = 0;
			filt_level = 0;
			voltage_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BIAS: bias_q = cfg_wdata[VOLT_W-1:0];
					REG_W01, REG_W23, REG_W45, REG_W67: begin
						weight_q[2 * (cfg_index - REG_W01)] = cfg_wdata[VOLT_W-1:0];
						weight_q[2 * (cfg_index - REG_W01) + 1] = cfg_wdata[2*VOLT_W-1:VOLT_W];
					end
					REG_FILT_EN: filt_on_q = cfg_wdata[0];
					REG_FILT_COEF: coef_q = cfg_wdata[15:0];
					REG_SNAP_THR: snap_q = cfg_wdata[15:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				predict_voltage(code, fraction);
			end
			if (out_valid && out_ready) begin
				if (voltage_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: output beat %0d with no sample pending", $time,
							$signed(voltage));
					end
				end else begin
					volt_t want;
					want = voltage_due.pop_front();
					if (voltage !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: voltage expected %0d (0x%06h) got %0d (0x%06h)",
								$time, $signed(want), want, $signed(voltage), voltage);
						end
					end
				end
			end
			pending = voltage_due.size();
		end
	end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
module tb;
	import rldac_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 20;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_SAMPLES = 150;
	localparam logic [CFG_IDX_W-1:0] SPARE_REG_IDX = 4'hF;

	typedef enum int {
		RECV_ALWAYS,
		RECV_RUNS,
		RECV_RANDOM
	} recv_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	logic [CODE_W-1:0]     code;
	logic [FRAC_W-1:0]     fraction;
	logic                  out_valid;
	logic                  out_ready;
	volt_t                 voltage;
	int                    fail_count;
	int                    pending;

	int         cycle_count;
	int         burst_left;
	int         run_left;
	logic       gaps_on;
	recv_mode_t recv_mode;
	volt_t      ladder_w [NUM_WEIGHTS];

	resistor_ladder_dac_with_rc_filter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.code      (code),
		.fraction  (fraction),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.voltage   (voltage)
	);

	rldac_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.code       (code),
		.fraction   (fraction),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.voltage    (voltage),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("resistor_ladder_dac_with_rc_filter_unit verification failed");
			$finish;
		end
	end

	// The receiver keeps its own stall pattern, independent of the sender.
	always @(negedge clk) begin
		case (recv_mode)
			RECV_ALWAYS: out_ready = 1'b1;
			RECV_RUNS: begin
				if (run_left == 0) begin
					out_ready = ~out_ready;
					run_left = out_ready ? $urandom_range(1, 8) : $urandom_range(1, 12);
				end else begin
					run_left--;
				end
			end
			default: out_ready = ($urandom_range(0, 3) != 0);
		endcase
	end

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Unused upper bits of the bias, filter and threshold registers get random data; only the low bits count.
	task automatic load_setup(input volt_t bias, input logic en, input logic [15:0] coef,
		input logic [15:0] snap);
		set_reg(REG_BIAS, {24'($urandom), bias});
		set_reg(REG_W01, {ladder_w[1], ladder_w[0]});
		set_reg(REG_W23, {ladder_w[3], ladder_w[2]});
		set_reg(REG_W45, {ladder_w[5], ladder_w[4]});
		set_reg(REG_W67, {ladder_w[7], ladder_w[6]});
		set_reg(REG_FILT_EN, {47'({$urandom, $urandom}), en});
		set_reg(REG_FILT_COEF, {32'($urandom), coef});
		set_reg(REG_SNAP_THR, {32'($urandom), snap});
	endtask

	task automatic binary_ladder();
		for (int b = 0; b < NUM_WEIGHTS; b++) begin
			ladder_w[b] = volt_t'(24'h000200 << b);
		end
	endtask

	task automatic send_sample(input logic [CODE_W-1:0] c, input logic [FRAC_W-1:0] f);
		int gap;
		if (burst_left == 0) begin
			burst_left = gaps_on ? $urandom_range(1, 16) : 1000;
			gap = gaps_on ? $urandom_range(1, 10) : 0;
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		burst_left--;
		in_valid = 1'b1;
		code = c;
		fraction = f;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Waits until every sample has produced its beat, then lets the block go quiet.
	task automatic settle_all();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [FRAC_W-1:0] frac_v;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		code = '0;
		fraction = '0;
		out_ready = 1'b0;
		cycle_count = 0;
		burst_left = 0;
		run_left = 0;
		gaps_on = 1'b0;
		recv_mode = RECV_ALWAYS;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Register values straight out of reset.
		send_sample(8'h00, 16'h0000);
		send_sample(8'hFF, 16'h1234);
		settle_all();

		// Plain ladder, filter off: single bits, all bits, and interpolation.
		binary_ladder();
		load_setup(volt_t'(-24'sd65536), 1'b0, 16'h0000, 16'h0001);
		send_sample(8'h00, 16'h0000);
		send_sample(8'hFF, 16'h0000);
		send_sample(8'h01, 16'h0000);
		send_sample(8'h80, 16'h0000);
		send_sample(8'h55, 16'h0000);
		send_sample(8'hAA, 16'h0000);
		send_sample(8'h00, 16'hFFFF);
		send_sample(8'hFF, 16'h0001);
		send_sample(8'h00, 16'h8000);
		settle_all();

		// Ladder sum beyond both ends of the range.
		for (int b = 0; b < NUM_WEIGHTS; b++) begin
			ladder_w[b] = volt_t'(24'h7FFFFF);
		end
		load_setup(volt_t'(24'h7FFFFF), 1'b0, 16'h0000, 16'h0001);
		send_sample(8'hFF, 16'h0000);
		send_sample(8'h00, 16'hFFFF);
		settle_all();
		for (int b = 0; b < NUM_WEIGHTS; b++) begin
			ladder_w[b] = volt_t'(24'h800000);
		end
		load_setup(volt_t'(24'h800000), 1'b0, 16'h0000, 16'h0001);
		send_sample(8'hFF, 16'h8000);
		send_sample(8'h7F, 16'h0000);
		settle_all();

		// Filter on: a zero threshold never snaps; a wide one snaps any step smaller than itself.
		binary_ladder();
		load_setup(volt_t'(24'h000000), 1'b1, 16'h8000, 16'h0000);
		send_sample(8'hFF, 16'h0000);
		send_sample(8'hFF, 16'h0000);
		send_sample(8'h00, 16'h0000);
		settle_all();
		set_reg(SPARE_REG_IDX, 48'({$urandom, $urandom}));
		set_reg(REG_FILT_COEF, 48'h0);
		set_reg(REG_SNAP_THR, 48'hFFFF);
		send_sample(8'h03, 16'h0000);
		send_sample(8'hFF, 16'h0000);
		settle_all();
		set_reg(REG_FILT_COEF, 48'hFFFF);
		set_reg(REG_SNAP_THR, 48'h0001);
		send_sample(8'h80, 16'h0000);
		send_sample(8'h80, 16'h0000);
		settle_all();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			gaps_on = p[0];
			recv_mode = recv_mode_t'(p % 3);
			case (p)
				0: begin
					binary_ladder();
					load_setup(volt_t'(int'($urandom_range(0, 65535)) - 32768), 1'b0,
						16'($urandom), 16'($urandom));
				end
				1: begin
					for (int b = 0; b < NUM_WEIGHTS; b++) begin
						ladder_w[b] = volt_t'($urandom);
					end
					load_setup(volt_t'($urandom), 1'b1, 16'($urandom), 16'($urandom));
				end
				2: begin
					for (int b = 0; b < NUM_WEIGHTS; b++) begin
						ladder_w[b] = volt_t'($urandom) >>> 4;
					end
					load_setup(volt_t'($urandom) >>> 2, 1'b1, 16'hFFFF, 16'h0000);
				end
				3: begin
					for (int b = 0; b < NUM_WEIGHTS; b++) begin
						ladder_w[b] = volt_t'(int'($urandom_range(0, 65535)) - 32768);
					end
					load_setup(volt_t'(int'($urandom_range(0, 65535)) - 32768), 1'b1,
						16'h0000, 16'hFFFF);
				end
				4: begin
					for (int b = 0; b < NUM_WEIGHTS; b++) begin
						ladder_w[b] = volt_t'($urandom);
					end
					load_setup(volt_t'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
				end
				default: begin
					binary_ladder();
					load_setup(volt_t'($urandom) >>> 6, 1'b1, 16'($urandom_range(1, 16'h0800)),
						16'($urandom_range(0, 16)));
				end
			endcase
			for (int i = 0; i < PHASE_SAMPLES; i++) begin
				if (p == 2 && i == PHASE_SAMPLES / 2) begin
					settle_all();
				end
				case ($urandom_range(0, 7))
					0, 1: frac_v = 16'h0000;
					2: frac_v = 16'hFFFF;
					3: frac_v = 16'h0001;
					default: frac_v = 16'($urandom);
				endcase
				send_sample(8'($urandom_range(0, 255)), frac_v);
			end
			settle_all();
		end

		if (fail_count == 0 && pending == 0) begin
			$display("resistor_ladder_dac_with_rc_filter_unit verification clean");
		end else begin
			$display("resistor_ladder_dac_with_rc_filter_unit verification failed");
		end
		$finish;
	end

endmodule
